// ===== rtl/mhe_pkg.sv =====
`default_nettype none

package mhe_pkg;

    localparam int DATA_W       = 32;
    localparam int IDX_W        = 11;
    localparam int CAPACITY_DEF = 1024;

    typedef enum logic {
        OP_INSERT  = 1'b0,
        OP_EXTRACT = 1'b1
    } t_op;

endpackage

`default_nettype wire

// ===== rtl/max_heap_extract_top.sv =====
`default_nettype none
// Binary max-heap in one synchronous RAM, root at one-based position 1.
// Command channel: a word is taken at a rising edge with start high and busy low.
//   i_operation = insert: i_value is appended after the last entry (no sift-up).
//     The word finishes at that edge; busy stays low and no result follows,
//     unless the heap is full, in which case an error result follows.
//   i_operation = extract: the root is returned, the last entry moves to the root
//     and sinks toward the larger child while that child is strictly greater.
// Result channel: o_valid pulses for one cycle with o_max_value, o_final_index
//   (rest position of the moved entry, 0 if the heap became empty) and o_error.
//   The receiver cannot stall; each result is taken in its single strobe cycle.
// Sequence: an extract reads the root and the last entry on accept (S_LOAD takes them),
//   then per level reads both children through the RAM's two read ports (S_DESCEND)
//   and compares and writes back the parent (S_CMP), until the entry settles at a
//   leaf, stops on a compare, or the heap becomes empty. Errors return in the cycle
//   after accept.
// Reset (synchronous, active low) empties the heap; RAM contents are not cleared
//   and no clearing pass is needed, since no position beyond the last entry is ever used.
module max_heap_extract_top
    import mhe_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       start,
    output logic                      busy,
    input  wire                       i_operation,
    input  wire signed [DATA_W-1:0]   i_value,
    output logic                      o_valid,
    output logic signed [DATA_W-1:0]  o_max_value,
    output logic [IDX_W-1:0]          o_final_index,
    output logic                      o_error
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DESCEND,
        S_CMP
    } t_state;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_pos, n_pos;
    logic signed [DATA_W-1:0] r_top, n_top;
    logic signed [DATA_W-1:0] r_v, n_v;
    logic                     r_valid, n_valid;
    logic signed [DATA_W-1:0] r_max, n_max;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic                     r_err, n_err;

    logic signed [DATA_W-1:0] mem_heap [CAPACITY];
    logic signed [DATA_W-1:0] r_rd_a, r_rd_b;
    logic [AW-1:0]            rd_addr_a, rd_addr_b, wr_addr;
    logic                     wr_en;
    logic signed [DATA_W-1:0] wr_data;

    logic [CW:0]              l_idx, r_child, count_ext, pick_idx;
    logic                     pick_right;
    logic signed [DATA_W-1:0] pick_val;
    logic                     accept;

    assign accept    = start && (r_state == S_IDLE);
    assign count_ext = {1'b0, r_count};
    assign l_idx     = {r_pos, 1'b0};
    assign r_child   = l_idx + (CW+1)'(1);
    assign pick_right = (r_child <= count_ext) && (r_rd_b > r_rd_a);
    assign pick_val  = pick_right ? r_rd_b : r_rd_a;
    assign pick_idx  = pick_right ? r_child : l_idx;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_top     = r_top;
        n_v       = r_v;
        n_valid   = 1'b0;
        n_max     = r_max;
        n_idx     = r_idx;
        n_err     = 1'b0;
        rd_addr_a = '0;
        rd_addr_b = '0;
        wr_en     = 1'b0;
        wr_addr   = AW'(r_pos - CW'(1));
        wr_data   = r_v;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (t_op'(i_operation) == OP_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_valid = 1'b1;
                            n_max   = '0;
                            n_idx   = '0;
                            n_err   = 1'b1;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = AW'(r_count);
                            wr_data = i_value;
                            n_count = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        n_valid = 1'b1;
                        n_max   = '0;
                        n_idx   = '0;
                        n_err   = 1'b1;
                    end else begin
                        // root on port a, last entry on port b
                        rd_addr_b = AW'(r_count - CW'(1));
                        n_count   = r_count - CW'(1);
                        n_state   = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                n_top = r_rd_a;
                n_v   = r_rd_b;
                n_pos = CW'(1);
                if (r_count == '0) begin
                    n_valid = 1'b1;
                    n_max   = r_rd_a;
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_DESCEND;
                end
            end
            S_DESCEND: begin
                if (l_idx > count_ext) begin
                    // leaf: park the moving entry here
                    wr_en   = 1'b1;
                    n_valid = 1'b1;
                    n_max   = r_top;
                    n_idx   = IDX_W'(r_pos);
                    n_state = S_IDLE;
                end else begin
                    rd_addr_a = AW'(l_idx - (CW+1)'(1));
                    rd_addr_b = AW'(l_idx);
                    n_state   = S_CMP;
                end
            end
            S_CMP: begin
                wr_en = 1'b1;
                if (pick_val > r_v) begin
                    // promote the child, keep sinking
                    wr_data = pick_val;
                    n_pos   = CW'(pick_idx);
                    n_state = S_DESCEND;
                end else begin
                    n_valid = 1'b1;
                    n_max   = r_top;
                    n_idx   = IDX_W'(r_pos);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_heap[wr_addr] <= wr_data;
        end
        r_rd_a <= mem_heap[rd_addr_a];
        r_rd_b <= mem_heap[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_top <= n_top;
        r_v   <= n_v;
        r_max <= n_max;
        r_idx <= n_idx;
        r_err <= n_err;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_max_value   = r_max;
    assign o_final_index = r_idx;
    assign o_error       = r_err;

endmodule

`default_nettype wire

// ===== rtl/mhe_checker.sv =====
`default_nettype none

module mhe_checker
    import mhe_pkg::*;
(
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      start,
    input wire                      busy,
    input wire                      i_operation,
    input wire                      o_valid,
    input wire signed [DATA_W-1:0]  o_max_value,
    input wire [IDX_W-1:0]          o_final_index,
    input wire                      o_error
);

    // reset leaves the block idle with no word in flight
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_valid))
        else $error("block not idle after reset");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_max_value == '0 && o_final_index == '0))
        else $error("error word carries payload");

    a_insert_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == OP_INSERT) |=> !busy)
        else $error("insert left the block busy");

    a_extract_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == OP_EXTRACT) |=> (busy || (o_valid && o_error)))
        else $error("extract neither started nor failed");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result word while busy");

endmodule

bind max_heap_extract_top mhe_checker u_mhe_checker (.*);

`default_nettype wire
